// ===== hw/rtl/ook_remote_pulse_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// ook remote pulse decoder assertion macros
// shared concurrent assertion forms for the decoder checker
// ----------------------------------------------------------------------------
`ifndef OOK_REMOTE_PULSE_DECODER_ASSERT_SVH
`define OOK_REMOTE_PULSE_DECODER_ASSERT_SVH

// same-cycle implication
`define OKD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("okd assertion failed");

// next-cycle implication
`define OKD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("okd assertion failed");

`endif

// ===== hw/rtl/okd_pkg.sv =====
// ----------------------------------------------------------------------------
// okd_pkg
// types and constants shared by the ook remote pulse decoder modules
// ----------------------------------------------------------------------------
package okd_pkg;

   typedef enum logic [1:0] {
      NC_BAD     = 2'd0,
      NC_ONE_ONE = 2'd1,
      NC_ONE_TWO = 2'd2,
      NC_SYNC    = 2'd3
   } nc_class_type;

   typedef enum logic [1:0] {
      CC_BAD     = 2'd0,
      CC_ONE_TWO = 2'd1,
      CC_TWO_ONE = 2'd2,
      CC_ONE_ONE = 2'd3
   } cc_class_type;

   typedef enum logic [1:0] {
      REG_MIN_PULSE    = 2'd0,
      REG_SHORT_LIMIT  = 2'd1,
      REG_MEDIUM_LIMIT = 2'd2,
      REG_SYNC_LIMIT   = 2'd3
   } reg_index_type;

   localparam int CSR_INDEX_BITS = 2;

   localparam logic [6:0] LONG_LEN   = 7'd66;
   localparam logic [6:0] SHORT_LEN  = 7'd25;
   localparam logic [6:0] COUNT_MAX  = 7'd127;
   localparam logic [3:0] CLASSIC_ON = 4'd14;

   localparam int MIN_PULSE_RESET    = 150;
   localparam int SHORT_LIMIT_RESET  = 400;
   localparam int MEDIUM_LIMIT_RESET = 1500;
   localparam int SYNC_LIMIT_RESET   = 3000;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;

   localparam int RSP_BITS = 40;

   // classified symbol handed from front to back
   typedef struct packed {
      nc_class_type nc;
      cc_class_type cc;
      logic         last;
   } sym_type;

   // result item, frame_valid in the lowest bit
   typedef struct packed {
      logic [1:0]  switch_state;
      logic [3:0]  unit_number;
      logic [25:0] device_address;
      logic        frame_format;
      logic        frame_valid;
   } rsp_type;

endpackage

// ===== hw/rtl/okd_front.sv =====
// ----------------------------------------------------------------------------
// okd_front
// holds the timing registers and classifies each symbol for both framings
// ----------------------------------------------------------------------------
module okd_front
   import okd_pkg::*;
#(
   parameter int DURATION_BITS = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [DURATION_BITS-1:0]   csr_wdata,
   input  logic [DURATION_BITS-1:0]   duration_high,
   input  logic [DURATION_BITS-1:0]   duration_low,
   input  logic                       last_symbol,
   output sym_type                    sym
);

   localparam int WB = DURATION_BITS + 2;

   logic [DURATION_BITS-1:0] min_pulse_ff, short_limit_ff, medium_limit_ff, sync_limit_ff;
   logic [DURATION_BITS-1:0] new_dur;
   logic                     too_short;
   logic                     d0_lt_d1;
   logic [WB-1:0]            d0_x1, d1_x1, d0_x2, d1_x2, d0_x4, d1_x4;
   nc_class_type             nc;
   cc_class_type             cc;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff    <= DURATION_BITS'(MIN_PULSE_RESET);
         short_limit_ff  <= DURATION_BITS'(SHORT_LIMIT_RESET);
         medium_limit_ff <= DURATION_BITS'(MEDIUM_LIMIT_RESET);
         sync_limit_ff   <= DURATION_BITS'(SYNC_LIMIT_RESET);
      end else if (csr_we) begin
         case (csr_index)
            REG_MIN_PULSE:    min_pulse_ff    <= csr_wdata;
            REG_SHORT_LIMIT:  short_limit_ff  <= csr_wdata;
            REG_MEDIUM_LIMIT: medium_limit_ff <= csr_wdata;
            REG_SYNC_LIMIT:   sync_limit_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign too_short = (duration_high < min_pulse_ff) || (duration_low < min_pulse_ff);
   assign d0_lt_d1  = duration_high < duration_low;
   assign new_dur   = d0_lt_d1 ? duration_low : duration_high;

   assign d0_x1 = {2'b00, duration_high};
   assign d1_x1 = {2'b00, duration_low};
   assign d0_x2 = {1'b0, duration_high, 1'b0};
   assign d1_x2 = {1'b0, duration_low, 1'b0};
   assign d0_x4 = {duration_high, 2'b00};
   assign d1_x4 = {duration_low, 2'b00};

   always_comb begin
      nc = NC_BAD;
      if (!too_short) begin
         if (new_dur < short_limit_ff) begin
            nc = NC_ONE_ONE;
         end else if (d0_lt_d1 && (new_dur < medium_limit_ff)) begin
            nc = NC_ONE_TWO;
         end else if (d0_lt_d1 && (new_dur < sync_limit_ff)) begin
            nc = NC_SYNC;
         end
      end
   end

   always_comb begin
      cc = CC_BAD;
      if (!too_short) begin
         if (d0_lt_d1) begin
            if (d1_x1 >= d0_x4) begin
               cc = CC_BAD;
            end else if (d1_x1 >= d0_x2) begin
               cc = CC_ONE_TWO;
            end else begin
               cc = CC_ONE_ONE;
            end
         end else begin
            if (d0_x1 >= d1_x4) begin
               cc = CC_BAD;
            end else if (d0_x1 >= d1_x2) begin
               cc = CC_TWO_ONE;
            end else begin
               cc = CC_ONE_ONE;
            end
         end
      end
   end

   assign sym.nc   = nc;
   assign sym.cc   = cc;
   assign sym.last = last_symbol;

endmodule

// ===== hw/rtl/okd_queue.sv =====
// ----------------------------------------------------------------------------
// okd_queue
// short queue of classified symbols between the front and the back
// ----------------------------------------------------------------------------
module okd_queue
   import okd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  sym_type in_sym,
   output logic    out_valid,
   input  logic    out_ready,
   output sym_type out_sym
);

   sym_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_sym   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_sym;
      end
   end

endmodule

// ===== hw/rtl/okd_back.sv =====
// ----------------------------------------------------------------------------
// okd_back
// assembles both framings from classified symbols and registers the result
// ----------------------------------------------------------------------------
module okd_back
   import okd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  sym_type in_sym,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   logic [6:0]   count_ff, count_in;
   logic [31:0]  long_code_ff, long_code_in;
   logic [11:0]  short_code_ff, short_code_in;
   logic         long_ok_ff, long_ok_in;
   logic         short_ok_ff, short_ok_in;
   nc_class_type long_pend_ff, long_pend_in;
   cc_class_type short_pend_ff, short_pend_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;
   logic         pop;

   assign in_ready = !in_sym.last || !rsp_valid_ff || rsp_ready;
   assign pop      = in_valid && in_ready;

   always_comb begin
      count_in      = count_ff;
      long_code_in  = long_code_ff;
      short_code_in = short_code_ff;
      long_ok_in    = long_ok_ff;
      short_ok_in   = short_ok_ff;
      long_pend_in  = long_pend_ff;
      short_pend_in = short_pend_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (pop) begin
         // new framing
         if (count_ff == '0) begin
            if (in_sym.nc != NC_SYNC) begin
               long_ok_in = 1'b0;
            end
         end else if (count_ff < LONG_LEN - 7'd1) begin
            if (count_ff[0]) begin
               long_pend_in = in_sym.nc;
            end else if (long_pend_ff == NC_ONE_TWO && in_sym.nc == NC_ONE_ONE) begin
               long_code_in = {long_code_ff[30:0], 1'b1};
            end else if (long_pend_ff == NC_ONE_ONE && in_sym.nc == NC_ONE_TWO) begin
               long_code_in = {long_code_ff[30:0], 1'b0};
            end else begin
               long_ok_in = 1'b0;
            end
         end

         // classic framing
         if (count_ff < SHORT_LEN - 7'd1) begin
            if (!count_ff[0]) begin
               short_pend_in = in_sym.cc;
            end else if (short_pend_ff != CC_ONE_TWO) begin
               short_ok_in = 1'b0;
            end else if (in_sym.cc == CC_ONE_TWO) begin
               short_code_in = {1'b0, short_code_ff[11:1]};
            end else if (in_sym.cc == CC_TWO_ONE) begin
               short_code_in = {1'b1, short_code_ff[11:1]};
            end else begin
               short_ok_in = 1'b0;
            end
         end

         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 7'd1;
         end

         if (in_sym.last) begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            if (count_in == LONG_LEN && long_ok_in) begin
               rsp_in.frame_valid    = 1'b1;
               rsp_in.frame_format   = 1'b0;
               rsp_in.device_address = long_code_in[31:6];
               rsp_in.unit_number    = long_code_in[3:0];
               rsp_in.switch_state   = long_code_in[5:4];
            end else if (count_in == SHORT_LEN && short_ok_in) begin
               rsp_in.frame_valid    = 1'b1;
               rsp_in.frame_format   = 1'b1;
               rsp_in.device_address = {22'd0, short_code_in[3:0]};
               rsp_in.unit_number    = short_code_in[7:4];
               rsp_in.switch_state   = {1'b0, short_code_in[11:8] == CLASSIC_ON};
            end
            count_in      = '0;
            long_code_in  = '0;
            short_code_in = '0;
            long_ok_in    = 1'b1;
            short_ok_in   = 1'b1;
            long_pend_in  = NC_BAD;
            short_pend_in = CC_BAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         long_code_ff  <= '0;
         short_code_ff <= '0;
         long_ok_ff    <= 1'b1;
         short_ok_ff   <= 1'b1;
         long_pend_ff  <= NC_BAD;
         short_pend_ff <= CC_BAD;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         long_code_ff  <= long_code_in;
         short_code_ff <= short_code_in;
         long_ok_ff    <= long_ok_in;
         short_ok_ff   <= short_ok_in;
         long_pend_ff  <= long_pend_in;
         short_pend_ff <= short_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== hw/rtl/ook_remote_pulse_decoder.sv =====
// a symbol that ends a capture is held in the queue, then the decoder registers its result item
// throughput: one symbol per cycle, but a last symbol waits while an earlier result item is not yet taken
// a two-item queue parts the classifier from the decoder, the result sits in a register
// reset: synchronous, active high; clears the capture state, queue and result valid,
// and restores the timing registers to 150, 400, 1500 and 3000
// ----------------------------------------------------------------------------
// ook_remote_pulse_decoder
// pulse-width decoder for on-off keyed remotes, new 32-bit and classic 12-bit codes
// ----------------------------------------------------------------------------
module ook_remote_pulse_decoder
   import okd_pkg::*;
#(
   parameter int DURATION_BITS = 15
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_we,
   input  logic [CSR_INDEX_BITS-1:0]                csr_index,
   input  logic [DURATION_BITS-1:0]                 csr_wdata,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // duration_high, duration_low, zero fill
   input  logic [((2*DURATION_BITS+7)/8)*8-1:0]     req_tdata,
   input  logic                                     req_tlast,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // frame_valid, frame_format, device_address, unit_number, switch_state, zero fill
   output logic [RSP_BITS-1:0]                      rsp_tdata
);

   sym_type front_sym, back_sym;
   logic    back_valid, back_ready;
   rsp_type rsp;

   okd_front #(
      .DURATION_BITS(DURATION_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .duration_high (req_tdata[DURATION_BITS-1:0]),
      .duration_low  (req_tdata[2*DURATION_BITS-1:DURATION_BITS]),
      .last_symbol   (req_tlast),
      .sym           (front_sym)
   );

   okd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sym    (front_sym),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_sym   (back_sym)
   );

   okd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (back_valid),
      .in_ready  (back_ready),
      .in_sym    (back_sym),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {(RSP_BITS-$bits(rsp_type))'(0), rsp};

endmodule

// ===== hw/rtl/okd_checker.sv =====
// ----------------------------------------------------------------------------
// okd_checker
// port-level checks on the result channel of the pulse decoder
// ----------------------------------------------------------------------------
`include "ook_remote_pulse_decoder_assert.svh"

module okd_checker
   import okd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata
);

   `OKD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `OKD_ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[RSP_BITS-1:1] == '0)
   `OKD_ASSERT_IMPLY(a_classic_narrow, clock, reset, rsp_tvalid && rsp_tdata[1], rsp_tdata[0] && rsp_tdata[27:6] == '0 && !rsp_tdata[33])
   `OKD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind ook_remote_pulse_decoder okd_checker u_okd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
